### src/wmcfd_pkg.sv
// ----------------------------------------------------------------------------
// wmcfd_pkg
// Shared types and constants for the compact meter frame decoder.
// ----------------------------------------------------------------------------
package wmcfd_pkg;

	// Frame index saturates here.
	localparam logic [7:0]  MAX_FRAME_BYTES = 8'd255;

	localparam logic [7:0]  COMPACT_TYPE    = 8'h79;
	localparam logic [7:0]  LONG_TYPE       = 8'h78;
	localparam logic [15:0] CRC_POLY        = 16'h3D65;

	// Byte positions within the frame
	localparam logic [7:0]  POS_CRC_LO      = 8'd0;
	localparam logic [7:0]  POS_CRC_HI      = 8'd1;
	localparam logic [7:0]  POS_TYPE        = 8'd2;
	localparam logic [7:0]  POS_TOTAL_FIRST = 8'd9;
	localparam logic [7:0]  POS_TOTAL_LAST  = 8'd12;
	localparam logic [7:0]  POS_TARGET_FIRST = 8'd13;
	localparam logic [7:0]  POS_TARGET_LAST = 8'd16;
	localparam logic [7:0]  POS_FLOW        = 8'd17;
	localparam logic [7:0]  POS_AMBIENT     = 8'd18;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_LONG    = 3'd1,
		ST_UNKNOWN = 3'd2,
		ST_CRC_ERR = 3'd3,
		ST_SHORT   = 3'd4
	} status_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] total_volume;
		logic [31:0] target_volume;
		logic [7:0]  flow_temperature;
		logic [7:0]  ambient_temperature;
	} result_t;

	// Control from the handshake stage to the frame tracker
	typedef struct packed {
		logic take;
		logic last;
	} step_ctrl_t;

endpackage

### src/wmcfd_crc8.sv
// ----------------------------------------------------------------------------
// wmcfd_crc8
// One-byte update of the EN 13757 CRC-16, MSB first.
// ----------------------------------------------------------------------------
module wmcfd_crc8
	import wmcfd_pkg::*;
(
	input  logic [15:0] crc,
	input  logic [7:0]  data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		logic [7:0]  d;
		logic        fb;
		c = crc;
		d = data;
		for (int k = 0; k < 8; k++) begin
			fb = c[15] ^ d[7];
			c  = {c[14:0], 1'b0};
			if (fb) begin
				c = c ^ CRC_POLY;
			end
			d = {d[6:0], 1'b0};
		end
		crc_next = c;
	end

endmodule

### src/wmcfd_frame.sv
// ----------------------------------------------------------------------------
// wmcfd_frame
// Frame tracker: byte index, CRC, captured fields and final status.
// ----------------------------------------------------------------------------
module wmcfd_frame
	import wmcfd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_ctrl_t ctrl,
	input  logic [7:0] frame_byte,
	output result_t    res
);

	logic [7:0]  byte_index_q, byte_index_n;
	logic [15:0] crc_q, crc_n, crc_upd;
	logic [15:0] rx_crc_q, rx_crc_n;
	logic [7:0]  frame_type_q, frame_type_n;
	logic [31:0] total_q, total_n;
	logic [31:0] target_q, target_n;
	logic [7:0]  flow_q, flow_n;
	logic [7:0]  ambient_q, ambient_n;
	logic [7:0]  lane_off;

	wmcfd_crc8 u_crc (
		.crc      (crc_q),
		.data     (frame_byte),
		.crc_next (crc_upd)
	);

	// Fold the current byte into the frame state
	always_comb begin
		byte_index_n = byte_index_q;
		crc_n        = crc_q;
		rx_crc_n     = rx_crc_q;
		frame_type_n = frame_type_q;
		total_n      = total_q;
		target_n     = target_q;
		flow_n       = flow_q;
		ambient_n    = ambient_q;
		lane_off     = 8'd0;

		if (byte_index_q == POS_CRC_LO) begin
			rx_crc_n = {8'h00, frame_byte};
		end else if (byte_index_q == POS_CRC_HI) begin
			rx_crc_n[15:8] = frame_byte;
		end
		if (byte_index_q == POS_TYPE) begin
			frame_type_n = frame_byte;
		end
		if (byte_index_q >= POS_TYPE) begin
			crc_n = crc_upd;
		end

		if (byte_index_q >= POS_TOTAL_FIRST && byte_index_q <= POS_TOTAL_LAST) begin
			lane_off = byte_index_q - POS_TOTAL_FIRST;
			total_n[{lane_off[1:0], 3'b000} +: 8] = frame_byte;
		end else if (byte_index_q >= POS_TARGET_FIRST && byte_index_q <= POS_TARGET_LAST) begin
			lane_off = byte_index_q - POS_TARGET_FIRST;
			target_n[{lane_off[1:0], 3'b000} +: 8] = frame_byte;
		end else if (byte_index_q == POS_FLOW) begin
			flow_n = frame_byte;
		end else if (byte_index_q == POS_AMBIENT) begin
			ambient_n = frame_byte;
		end

		if (byte_index_q < MAX_FRAME_BYTES) begin
			byte_index_n = byte_index_q + 8'd1;
		end
	end

	// Classify the frame as it would stand after this byte
	always_comb begin
		status_t st;
		priority if (byte_index_q < POS_TYPE) begin
			st = ST_SHORT;
		end else if (frame_type_n == LONG_TYPE) begin
			st = ST_LONG;
		end else if (frame_type_n != COMPACT_TYPE) begin
			st = ST_UNKNOWN;
		end else if (~crc_n != rx_crc_n) begin
			st = ST_CRC_ERR;
		end else if (byte_index_q < POS_AMBIENT) begin
			st = ST_SHORT;
		end else begin
			st = ST_OK;
		end

		res.status = st;
		if (st == ST_OK) begin
			res.total_volume        = total_n;
			res.target_volume       = target_n;
			res.flow_temperature    = flow_n;
			res.ambient_temperature = ambient_n;
		end else begin
			res.total_volume        = 32'd0;
			res.target_volume       = 32'd0;
			res.flow_temperature    = 8'd0;
			res.ambient_temperature = 8'd0;
		end
	end

	// Advance on each byte; clear after the final byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q <= '0;
			crc_q        <= '0;
			rx_crc_q     <= '0;
			frame_type_q <= '0;
			total_q      <= '0;
			target_q     <= '0;
			flow_q       <= '0;
			ambient_q    <= '0;
		end else if (ctrl.take) begin
			if (ctrl.last) begin
				byte_index_q <= '0;
				crc_q        <= '0;
				rx_crc_q     <= '0;
				frame_type_q <= '0;
				total_q      <= '0;
				target_q     <= '0;
				flow_q       <= '0;
				ambient_q    <= '0;
			end else begin
				byte_index_q <= byte_index_n;
				crc_q        <= crc_n;
				rx_crc_q     <= rx_crc_n;
				frame_type_q <= frame_type_n;
				total_q      <= total_n;
				target_q     <= target_n;
				flow_q       <= flow_n;
				ambient_q    <= ambient_n;
			end
		end
	end

endmodule

### src/wmcfd_top.sv
// ----------------------------------------------------------------------------
// wmbus_compact_frame_decoder_top
// Compact meter frame decoder with EN 13757 CRC-16 check.
// ----------------------------------------------------------------------------
// Result path: a final byte's result reaches the result port through the
//   input register, then the result register.
// Throughput: one byte per cycle; the CRC byte update and the field capture
//   sit in one combinational step between the two registers. A final byte
//   waits in the input register only while an earlier result is stalled.
// Reset: arst_n clears the frame state and both valid flags at once.
// ----------------------------------------------------------------------------
module wmbus_compact_frame_decoder_top
	import wmcfd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	logic       s1_valid;
	item_t      item_s1;
	logic       res_free;
	logic       advance;
	step_ctrl_t ctrl;
	result_t    res_comb;
	result_t    result_q;
	logic       result_valid_q;

	// The result register can take a new value once the current one leaves
	assign res_free = !result_valid_q || !result_stall;

	// Only a final byte needs room downstream; other bytes always move on
	assign advance = s1_valid && (!item_s1.last_byte || res_free);

	// Hold the input register while its byte cannot advance
	assign item_stall = s1_valid && !advance;

	assign ctrl.take = advance;
	assign ctrl.last = item_s1.last_byte;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (!item_stall) begin
			s1_valid <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	wmcfd_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.frame_byte (item_s1.frame_byte),
		.res        (res_comb)
	);

	// Result register: drop a taken transaction, load the next final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.last_byte) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_byte) begin
			result_q <= res_comb;
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Stall is only raised while a byte sits in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> s1_valid)
		else $error("input stalled with empty input register");

	// A new result transaction follows a final byte leaving the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(s1_valid && item_s1.last_byte))
		else $error("result raised without a final byte");

	// Readings are zero unless the frame decoded cleanly
	assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status != ST_OK) |->
			(result.total_volume == 32'd0 && result.target_volume == 32'd0 &&
			 result.flow_temperature == 8'd0 && result.ambient_temperature == 8'd0))
		else $error("readings present on a failed frame");

endmodule
